>>> sv/diamond_difference_sweep_cell_top_macros.svh
// Assertion macros for the diamond-difference sweep cell checker.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef DIAMOND_DIFFERENCE_SWEEP_CELL_TOP_MACROS_SVH
`define DIAMOND_DIFFERENCE_SWEEP_CELL_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define DDSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Next-cycle implication built on the macro above.
`define DDSC_ASSERT_NEXT(lbl, pre, post, msg) \
  `DDSC_ASSERT(lbl, (pre) |=> (post), msg)

`endif

>>> sv/ddsc_pkg.sv
// Shared types, constants and saturating fixed-point helpers of the sweep cell.
// No dependencies; used by the divider, multiplier, top level and testbench.
package ddsc_pkg;

  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_REFLECT = 2'd1,
    MODE_RIGHT   = 2'd2,
    MODE_LEFT    = 2'd3
  } mode_e;

  localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

  localparam int DIV_W  = 96;
  localparam int STEP_W = 7;
  localparam logic [STEP_W-1:0] DIV_STEPS_B   = 7'd66;
  localparam logic [STEP_W-1:0] DIV_STEPS_PSI = 7'd96;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [DIV_W-1:0]  dividend;
    logic [63:0]       divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] x;
    logic [63:0] y;
  } mul_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] product;
  } mul_rsp_t;

  function automatic logic [63:0] magn(input logic [63:0] x);
    return x[63] ? (64'd0 - x) : x;
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a + b;
    if ((a[63] == b[63]) && (r[63] != a[63])) begin
      r = a[63] ? SMIN : SMAX;
    end
    return r;
  endfunction

  function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a - b;
    if ((a[63] != b[63]) && (r[63] != a[63])) begin
      r = a[63] ? SMIN : SMAX;
    end
    return r;
  endfunction

  function automatic logic [63:0] sat_signed(input logic neg, input logic [95:0] mag);
    logic [63:0] lim;
    logic [63:0] lo;
    lim = neg ? SMIN : SMAX;
    lo  = mag[63:0];
    if ((mag[95:64] != 32'd0) || (lo > lim)) begin
      lo = lim;
    end
    return neg ? (64'd0 - lo) : lo;
  endfunction

endpackage

>>> sv/ddsc_div.sv
// Radix-2 restoring divider shared by both divisions of a cell step.
// Depends on ddsc_pkg for the request and response structs.
module ddsc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ddsc_pkg::div_req_t req_i,
  output ddsc_pkg::div_rsp_t rsp_o
);
  import ddsc_pkg::*;

  logic [63:0]       rem_q;
  logic [63:0]       dvs_q;
  logic [DIV_W-1:0]  quo_q;
  logic [STEP_W-1:0] cnt_q;
  logic              run_q;
  logic              done_q;
  logic [64:0]       shifted;
  logic [64:0]       trial;

  assign shifted = {rem_q, quo_q[DIV_W-1]};
  assign trial   = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (run_q) begin
      if (!trial[64]) begin
        rem_q <= trial[63:0];
        quo_q <= {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_q <= shifted[63:0];
        quo_q <= {quo_q[DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= !req_i.start && run_q && (cnt_q == 7'd1);
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= req_i.steps;
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == 7'd1) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

>>> sv/ddsc_mul.sv
// 64 by 64 unsigned multiplier built from four 32 by 32 partial products.
// Depends on ddsc_pkg for the request and response structs.
module ddsc_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ddsc_pkg::mul_req_t req_i,
  output ddsc_pkg::mul_rsp_t rsp_o
);
  import ddsc_pkg::*;

  logic [63:0]  x_q;
  logic [63:0]  y_q;
  logic [63:0]  pp_q;
  logic [1:0]   pp_sh_q;
  logic [127:0] acc_q;
  logic [2:0]   ph_q;
  logic         run_q;
  logic         done_q;
  logic [31:0]  a_sel;
  logic [31:0]  b_sel;
  logic [63:0]  pp_d;
  logic [127:0] pp_ext;

  always_comb begin
    unique case (ph_q[1:0])
      2'd0: begin a_sel = x_q[31:0];  b_sel = y_q[31:0];  end
      2'd1: begin a_sel = x_q[31:0];  b_sel = y_q[63:32]; end
      2'd2: begin a_sel = x_q[63:32]; b_sel = y_q[31:0];  end
      default: begin a_sel = x_q[63:32]; b_sel = y_q[63:32]; end
    endcase
  end

  assign pp_d = a_sel * b_sel;

  always_comb begin
    unique case (pp_sh_q)
      2'd0:    pp_ext = {64'd0, pp_q};
      2'd3:    pp_ext = {pp_q, 64'd0};
      default: pp_ext = {32'd0, pp_q, 32'd0};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q   <= req_i.x;
      y_q   <= req_i.y;
      acc_q <= '0;
    end else if (run_q) begin
      if (ph_q != 3'd4) begin
        pp_q    <= pp_d;
        pp_sh_q <= ph_q[1:0];
      end
      if (ph_q != 3'd0) begin
        acc_q <= acc_q + pp_ext;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      ph_q   <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= !req_i.start && run_q && (ph_q == 3'd4);
      if (req_i.start) begin
        run_q <= 1'b1;
        ph_q  <= '0;
      end else if (run_q) begin
        ph_q <= ph_q + 3'd1;
        if (ph_q == 3'd4) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.product = acc_q;

endmodule

>>> sv/ddsc_flux_mem.sv
// Angular flux store: one write port, one registered read port.
// Clears every entry after reset; no package dependency.
module ddsc_flux_mem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [63:0]   wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [63:0]   rd_data_o,
  output logic          busy_o
);

  logic [63:0]   mem [DEPTH];
  logic [63:0]   rd_q;
  logic [AW-1:0] clr_addr_q;
  logic          clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_addr_q] <= '0;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;
  assign busy_o    = clr_q;

endmodule

>>> sv/diamond_difference_sweep_cell_top.sv
// Top level of the diamond-difference sweep cell: sequencer, flux store,
// shared divider and multiplier. Depends on ddsc_pkg and the ddsc_* modules.
//
//   channel | signals                                      | direction
//   --------+----------------------------------------------+-----------
//   in      | in_valid_i, in_stall_o, fields               | to block
//   out     | out_valid_o, out_stall_i, psi_o, div_fault_o | from block
//   cfg     | cfg_valid_i, cfg_ready_o                     | to block
//
// A load or reflect item passes the read, dispatch, store and output states;
// a full cell step runs the shared radix-2 divider for 66 and 96 iterations.
// A zero step width or a zero denominator ends a step earlier.
// After reset the flux store clears its NUM_GROUPS*MAX_DIRS entries
// (128 by default) with in_stall_o high; configuration writes are taken.
// A stalled result holds in the output register while the next item is taken.
module diamond_difference_sweep_cell_top #(
  parameter int NUM_GROUPS = 8,
  parameter int MAX_DIRS   = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic [2:0]         group_i,
  input  logic [3:0]         direction_i,
  input  logic signed [33:0] mu_i,
  input  logic [62:0]        step_width_i,
  input  logic [62:0]        total_xs_i,
  input  logic signed [63:0] region_source_i,
  input  logic signed [63:0] scatter_source_i,
  input  logic signed [63:0] boundary_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [63:0] psi_o,
  output logic               div_fault_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [4:0]         cfg_data_i
);
  import ddsc_pkg::*;

  localparam int DEPTH = NUM_GROUPS * MAX_DIRS;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_READ  = 13'b0000000000010,
    S_DISP  = 13'b0000000000100,
    S_DIV1  = 13'b0000000001000,
    S_DEN   = 13'b0000000010000,
    S_CHK   = 13'b0000000100000,
    S_MUL   = 13'b0000001000000,
    S_SUMQ  = 13'b0000010000000,
    S_SUMS  = 13'b0000100000000,
    S_DIV2S = 13'b0001000000000,
    S_DIV2  = 13'b0010000000000,
    S_STORE = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_e;

  state_e      state_q, state_d;
  logic [4:0]  num_dirs_q;
  logic        out_valid_q;
  logic [63:0] psi_out_q;
  logic        fault_out_q;

  mode_e       mode_q;
  logic [2:0]  grp_q;
  logic [3:0]  dir_q;
  logic [63:0] mu_q;
  logic [62:0] h_q;
  logic [63:0] a_q;
  logic [63:0] src_q;
  logic [63:0] sct_q;
  logic [63:0] bnd_q;

  logic [63:0] psi_old_q;
  logic [63:0] b_q;
  logic [63:0] den_q;
  logic [63:0] d_q;
  logic [63:0] num_q;
  logic [63:0] res_q;
  logic        fault_q;
  logic        wr_q;

  logic          in_acc;
  logic          out_free;
  logic          is_step;
  logic          addr_ok;
  logic          mir_ok;
  logic [6:0]    mir_w;
  logic [AW-1:0] idx_addr;
  logic [AW-1:0] mir_addr;
  logic [AW-1:0] rd_addr;
  logic [63:0]   rd_data;
  logic          mem_busy;
  logic          mem_wr_en;
  logic [63:0]   mu_ext;
  logic [63:0]   mu_mag;
  logic          h_zero;

  div_req_t div_req;
  div_rsp_t div_rsp;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  assign in_stall_o  = (state_q != S_IDLE) || mem_busy;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign psi_o       = psi_out_q;
  assign div_fault_o = fault_out_q;

  assign mu_ext  = 64'(mu_i);
  assign mu_mag  = magn(mu_q);
  assign h_zero  = (h_q == 63'd0);
  assign is_step = (mode_q == MODE_RIGHT) || (mode_q == MODE_LEFT);

  assign addr_ok  = (32'(grp_q) < NUM_GROUPS) && (32'(dir_q) < MAX_DIRS);
  assign mir_w    = {2'b00, num_dirs_q} - 7'd1 - {3'b000, dir_q};
  assign mir_ok   = !mir_w[6] && (32'(mir_w[5:0]) < MAX_DIRS);
  assign idx_addr = AW'(32'(grp_q) * MAX_DIRS + 32'(dir_q));
  assign mir_addr = AW'(32'(grp_q) * MAX_DIRS + 32'(mir_w[5:0]));
  assign rd_addr  = ((mode_q == MODE_REFLECT) && mir_ok) ? mir_addr : idx_addr;
  assign mem_wr_en = (state_q == S_STORE) && wr_q;

  ddsc_flux_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (idx_addr),
    .wr_data_i (res_q),
    .rd_en_i   (state_q == S_READ),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .busy_o    (mem_busy)
  );

  ddsc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  ddsc_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  always_comb begin
    div_req = '0;
    mul_req = '0;
    if ((state_q == S_DISP) && addr_ok && is_step && !h_zero) begin
      div_req.start    = 1'b1;
      div_req.steps    = DIV_STEPS_B;
      div_req.dividend = {mu_mag[33:0], 62'd0};
      div_req.divisor  = {1'b0, h_q};
    end else if (state_q == S_DIV2S) begin
      div_req.start    = 1'b1;
      div_req.steps    = DIV_STEPS_PSI;
      div_req.dividend = {magn(num_q), 32'd0};
      div_req.divisor  = magn(den_q);
    end
    if ((state_q == S_CHK) && (den_q != 64'd0)) begin
      mul_req.start = 1'b1;
      mul_req.x     = magn(d_q);
      mul_req.y     = magn(psi_old_q);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc) state_d = S_READ;
      S_READ:  state_d = S_DISP;
      S_DISP: begin
        if (addr_ok && is_step) begin
          state_d = h_zero ? S_DEN : S_DIV1;
        end else begin
          state_d = S_STORE;
        end
      end
      S_DIV1:  if (div_rsp.done) state_d = S_DEN;
      S_DEN:   state_d = S_CHK;
      S_CHK:   state_d = (den_q == 64'd0) ? S_STORE : S_MUL;
      S_MUL:   if (mul_rsp.done) state_d = S_SUMQ;
      S_SUMQ:  state_d = S_SUMS;
      S_SUMS:  state_d = S_DIV2S;
      S_DIV2S: state_d = S_DIV2;
      S_DIV2:  if (div_rsp.done) state_d = S_STORE;
      S_STORE: state_d = S_OUT;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      num_dirs_q  <= 5'd2;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        num_dirs_q <= cfg_data_i;
      end
      if ((state_q == S_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          mode_q <= mode_e'(mode_i);
          grp_q  <= group_i;
          dir_q  <= direction_i;
          mu_q   <= (mode_e'(mode_i) == MODE_LEFT) ? (64'd0 - mu_ext) : mu_ext;
          h_q    <= step_width_i;
          a_q    <= {2'b00, total_xs_i[62:1]};
          src_q  <= region_source_i;
          sct_q  <= scatter_source_i;
          bnd_q  <= boundary_value_i;
        end
      end
      S_DISP: begin
        psi_old_q <= rd_data;
        fault_q   <= 1'b0;
        priority if (!addr_ok) begin
          res_q <= '0;
          wr_q  <= 1'b0;
        end else if (mode_q == MODE_LOAD) begin
          res_q <= bnd_q;
          wr_q  <= 1'b1;
        end else if (mode_q == MODE_REFLECT) begin
          res_q <= rd_data;
          wr_q  <= mir_ok;
        end else begin
          res_q <= '0;
          wr_q  <= 1'b0;
          if (h_zero) begin
            b_q <= (mu_q == 64'd0) ? 64'd0 : (mu_q[63] ? SMIN : SMAX);
          end
        end
      end
      S_DIV1: begin
        if (div_rsp.done) begin
          b_q <= sat_signed(mu_q[63], div_rsp.quotient);
        end
      end
      S_DEN: begin
        den_q <= sat_add(b_q, a_q);
        d_q   <= sat_sub(b_q, a_q);
      end
      S_CHK: begin
        if (den_q == 64'd0) begin
          res_q   <= psi_old_q;
          fault_q <= 1'b1;
        end
      end
      S_MUL: begin
        if (mul_rsp.done) begin
          num_q <= sat_signed(d_q[63] ^ psi_old_q[63], mul_rsp.product[127:32]);
        end
      end
      S_SUMQ:  num_q <= sat_add(num_q, src_q);
      S_SUMS:  num_q <= sat_add(num_q, sct_q);
      S_DIV2: begin
        if (div_rsp.done) begin
          res_q <= sat_signed(num_q[63] ^ den_q[63], div_rsp.quotient);
          wr_q  <= 1'b1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          psi_out_q   <= res_q;
          fault_out_q <= fault_q;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> sv/ddsc_checker.sv
// Port-level checker of the sweep cell and its bind to the top level.
// Depends on diamond_difference_sweep_cell_top_macros.svh.
`include "diamond_difference_sweep_cell_top_macros.svh"

module ddsc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] psi_o,
  input logic        div_fault_o
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] inflight_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= 2'd0;
    end else if (in_acc && !out_acc) begin
      inflight_q <= inflight_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      inflight_q <= inflight_q - 2'd1;
    end
  end

  `DDSC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(psi_o) && $stable(div_fault_o), "stalled result changed")
  `DDSC_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall_o, "item taken while busy")
  `DDSC_ASSERT(a_no_invented, out_valid_o |-> (inflight_q != 2'd0), "result without item")
  `DDSC_ASSERT(a_one_waiting, in_acc |-> (inflight_q <= 2'd1), "too many items in flight")

endmodule

bind diamond_difference_sweep_cell_top ddsc_checker u_ddsc_checker (.*);

>>> tb/diamond_difference_sweep_cell_top_tb.sv
// Self-checking testbench of the diamond-difference sweep cell: directed rows, then random
// sweeps under several idle patterns and mirror settings, checked against a flux predictor.
// Depends on ddsc_pkg and diamond_difference_sweep_cell_top.
module diamond_difference_sweep_cell_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ddsc_pkg::*;

  localparam int NUM_GROUPS = 8;
  localparam int MAX_DIRS   = 16;

  localparam int ITEMS_PER_PHASE = 100;
  localparam int NUM_PHASES      = 8;
  localparam int HOLD_CYCLES     = 1500;
  localparam int DRAIN_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT  = 20000;

  localparam logic [63:0] FX_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] FX_MIN   = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ONE      = 64'h0000_0001_0000_0000;
  localparam logic [63:0] TWO      = 64'h0000_0002_0000_0000;
  localparam logic [63:0] THREE    = 64'h0000_0003_0000_0000;
  localparam logic [63:0] FIVE     = 64'h0000_0005_0000_0000;
  localparam logic [63:0] SEVEN    = 64'h0000_0007_0000_0000;
  localparam logic [63:0] HALF     = 64'h0000_0000_8000_0000;
  localparam logic [63:0] QUARTER  = 64'h0000_0000_4000_0000;
  localparam logic [63:0] NEG_HALF = 64'hFFFF_FFFF_8000_0000;
  localparam logic [62:0] XS_MAX   = 63'h7FFF_FFFF_FFFF_FFFF;

  localparam logic [33:0] MU_ONE     = 34'h1_0000_0000;
  localparam logic [33:0] MU_NEG_ONE = 34'h3_0000_0000;
  localparam logic [33:0] MU_HALF    = 34'h0_8000_0000;
  localparam logic [33:0] MU_MAX     = 34'h1_FFFF_FFFF;
  localparam logic [33:0] MU_MIN     = 34'h2_0000_0000;

  typedef struct packed {
    mode_e       mode;
    logic [2:0]  group;
    logic [3:0]  direction;
    logic [33:0] mu;
    logic [62:0] step_width;
    logic [62:0] total_xs;
    logic [63:0] region_source;
    logic [63:0] scatter_source;
    logic [63:0] boundary_value;
  } cell_item_t;

  typedef struct packed {
    logic [63:0] psi;
    logic        fault;
  } cell_result_t;

  typedef struct packed {
    cell_item_t   item;
    logic         typed;
    cell_result_t res;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  mode_i = '0;
  logic [2:0]  group_i = '0;
  logic [3:0]  direction_i = '0;
  logic [33:0] mu_i = '0;
  logic [62:0] step_width_i = '0;
  logic [62:0] total_xs_i = '0;
  logic [63:0] region_source_i = '0;
  logic [63:0] scatter_source_i = '0;
  logic [63:0] boundary_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] psi_o;
  logic        div_fault_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [4:0]  cfg_data_i = '0;

  logic [63:0]  flux_model [NUM_GROUPS][MAX_DIRS];
  logic [4:0]   num_dirs_cfg;
  cell_result_t flux_expect_q [$];
  stim_row_t    directed_rows [$];
  cell_result_t head_result;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned quiet_cycles = 0;
  int unsigned failures = 0;

  logic [4:0] dirs_plan [NUM_PHASES] = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd7, 5'd8, 5'd17, 5'd2};

  wire in_fire  = in_valid_i && !in_stall_o;
  wire out_fire = out_valid_o && !out_stall_i;
  wire cfg_fire = cfg_valid_i && cfg_ready_o;

  diamond_difference_sweep_cell_top #(
    .NUM_GROUPS(NUM_GROUPS),
    .MAX_DIRS  (MAX_DIRS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .mode_i          (mode_i),
    .group_i         (group_i),
    .direction_i     (direction_i),
    .mu_i            (mu_i),
    .step_width_i    (step_width_i),
    .total_xs_i      (total_xs_i),
    .region_source_i (region_source_i),
    .scatter_source_i(scatter_source_i),
    .boundary_value_i(boundary_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .psi_o           (psi_o),
    .div_fault_o     (div_fault_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [63:0] abs64(input logic [63:0] x);
    return x[63] ? (64'd0 - x) : x;
  endfunction

  function automatic logic [63:0] add_clamp(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a + b;
    if ((a[63] == b[63]) && (r[63] != a[63])) begin
      r = a[63] ? FX_MIN : FX_MAX;
    end
    return r;
  endfunction

  function automatic logic [63:0] sub_clamp(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a - b;
    if ((a[63] != b[63]) && (r[63] != a[63])) begin
      r = a[63] ? FX_MIN : FX_MAX;
    end
    return r;
  endfunction

  function automatic logic [63:0] clamp_mag(input logic neg, input logic [127:0] mag);
    logic [127:0] lim;
    logic [127:0] m;
    lim = {64'd0, (neg ? FX_MIN : FX_MAX)};
    m = (mag > lim) ? lim : mag;
    return neg ? (64'd0 - m[63:0]) : m[63:0];
  endfunction

  function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, abs64(a)} * {64'd0, abs64(b)};
    return clamp_mag(a[63] ^ b[63], prod >> 32);
  endfunction

  // Quotient n * 2^32 / d, truncated toward zero; d is never zero here.
  function automatic logic [63:0] fx_div(input logic [63:0] n, input logic [63:0] d);
    logic [127:0] q;
    q = {32'd0, abs64(n), 32'd0} / {64'd0, abs64(d)};
    return clamp_mag(n[63] ^ d[63], q);
  endfunction

  function automatic cell_result_t sweep_predict(input cell_item_t it);
    cell_result_t res;
    logic [63:0]  mu;
    logic [63:0]  b;
    logic [63:0]  a;
    logic [63:0]  den;
    logic [63:0]  acc;
    int           mirror;
    res.fault = 1'b0;
    unique case (it.mode)
      MODE_LOAD: begin
        flux_model[it.group][it.direction] = it.boundary_value;
      end
      MODE_REFLECT: begin
        mirror = int'(num_dirs_cfg) - 1 - int'(it.direction);
        if (mirror >= 0 && mirror < MAX_DIRS) begin
          flux_model[it.group][it.direction] = flux_model[it.group][mirror];
        end
      end
      default: begin
        mu = {{30{it.mu[33]}}, it.mu};
        if (it.mode == MODE_LEFT) begin
          mu = 64'd0 - mu;
        end
        a = {2'b00, it.total_xs[62:1]};
        if (it.step_width == '0) begin
          b = (mu == '0) ? 64'd0 : (mu[63] ? FX_MIN : FX_MAX);
        end else begin
          b = fx_div(mu, {1'b0, it.step_width});
        end
        den = add_clamp(b, a);
        if (den == '0) begin
          res.fault = 1'b1;
        end else begin
          acc = fx_mul(sub_clamp(b, a), flux_model[it.group][it.direction]);
          acc = add_clamp(acc, it.region_source);
          acc = add_clamp(acc, it.scatter_source);
          flux_model[it.group][it.direction] = fx_div(acc, den);
        end
      end
    endcase
    res.psi = flux_model[it.group][it.direction];
    return res;
  endfunction

  function automatic cell_item_t mk(input mode_e mode, input int g, input int d,
                                    input logic [33:0] mu, input logic [63:0] h,
                                    input logic [63:0] xs, input logic [63:0] q,
                                    input logic [63:0] s, input logic [63:0] bv);
    cell_item_t it;
    it.mode           = mode;
    it.group          = 3'(g);
    it.direction      = 4'(d);
    it.mu             = mu;
    it.step_width     = h[62:0];
    it.total_xs       = xs[62:0];
    it.region_source  = q;
    it.scatter_source = s;
    it.boundary_value = bv;
    return it;
  endfunction

  function automatic void add_row(input cell_item_t it, input logic typed = 1'b0,
                                  input logic [63:0] psi = '0, input logic fault = 1'b0);
    stim_row_t row;
    row.item      = it;
    row.typed     = typed;
    row.res.psi   = psi;
    row.res.fault = fault;
    directed_rows.push_back(row);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] random_flux();
    logic [63:0] r;
    int unsigned pick;
    r = rand64();
    pick = $urandom_range(99);
    if (pick < 80) return {{24{r[39]}}, r[39:0]};
    if (pick < 94) return r;
    return pick[0] ? FX_MAX : FX_MIN;
  endfunction

  // Mostly physical sweeps: cosines within one, moderate widths and cross sections.
  function automatic cell_item_t random_item();
    cell_item_t  it;
    int unsigned pick;
    logic [31:0] m;
    it.mode      = mode_e'($urandom_range(3));
    it.group     = 3'($urandom);
    it.direction = 4'($urandom);
    m = $urandom;
    pick = $urandom_range(99);
    if (pick < 70) it.mu = $urandom_range(1) ? (34'd0 - {2'b00, m}) : {2'b00, m};
    else if (pick < 85) it.mu = 34'({$urandom, m});
    else if (pick < 90) it.mu = '0;
    else if (pick < 95) it.mu = $urandom_range(1) ? MU_MIN : MU_MAX;
    else it.mu = $urandom_range(1) ? MU_NEG_ONE : MU_ONE;
    pick = $urandom_range(99);
    if (pick < 70) it.step_width = {27'd0, 4'($urandom), 32'($urandom)};
    else if (pick < 82) it.step_width = 63'(rand64());
    else if (pick < 88) it.step_width = '0;
    else if (pick < 94) it.step_width = 63'd1;
    else it.step_width = XS_MAX;
    pick = $urandom_range(99);
    if (pick < 70) it.total_xs = {28'd0, 3'($urandom), 32'($urandom)};
    else if (pick < 85) it.total_xs = 63'(rand64());
    else if (pick < 92) it.total_xs = '0;
    else it.total_xs = XS_MAX;
    it.region_source  = random_flux();
    it.scatter_source = random_flux();
    it.boundary_value = random_flux();
    // Now and then the streaming term exactly cancels the half cross section.
    if (it.mode inside {MODE_RIGHT, MODE_LEFT} && $urandom_range(99) < 6) begin
      m = $urandom >> 1;
      it.step_width = ONE[62:0];
      it.mu = (it.mode == MODE_RIGHT) ? (34'd0 - {2'b00, m}) : {2'b00, m};
      it.total_xs = {30'd0, m, 1'($urandom)};
    end
    return it;
  endfunction

  task automatic send_item(input cell_item_t it, input logic typed, input cell_result_t res);
    cell_result_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    mode_i           <= it.mode;
    group_i          <= it.group;
    direction_i      <= it.direction;
    mu_i             <= it.mu;
    step_width_i     <= it.step_width;
    total_xs_i       <= it.total_xs;
    region_source_i  <= it.region_source;
    scatter_source_i <= it.scatter_source;
    boundary_value_i <= it.boundary_value;
    do @(posedge clk_i); while (in_stall_o);
    want = sweep_predict(it);
    flux_expect_q.push_back(typed ? res : want);
  endtask

  task automatic write_num_dirs(input logic [4:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    num_dirs_cfg = value;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain_results();
    while (flux_expect_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_fire) begin
      if (flux_expect_q.size() == 0) begin
        $error("result with no item pending: psi %h, div_fault %b", psi_o, div_fault_o);
        failures++;
      end else begin
        head_result = flux_expect_q.pop_front();
        if (psi_o !== head_result.psi) begin
          $error("psi: expected %h, got %h", head_result.psi, psi_o);
          failures++;
        end
        if (div_fault_o !== head_result.fault) begin
          $error("div_fault: expected %b, got %b", head_result.fault, div_fault_o);
          failures++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || in_fire || out_fire || cfg_fire) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    cell_result_t no_result;
    no_result = '0;
    foreach (flux_model[g, d]) flux_model[g][d] = '0;
    num_dirs_cfg = 5'd2;

    add_row(mk(MODE_RIGHT, 0, 0, MU_ONE, ONE, 0, 0, 0, 0), 1'b1, 64'd0, 1'b0);
    add_row(mk(MODE_REFLECT, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, 64'd0, 1'b0);
    add_row(mk(MODE_LOAD, 0, 1, 0, 0, 0, 0, 0, FX_MAX), 1'b1, FX_MAX, 1'b0);
    add_row(mk(MODE_REFLECT, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, FX_MAX, 1'b0);
    add_row(mk(MODE_LOAD, 7, 15, 0, 0, 0, 0, 0, FX_MIN), 1'b1, FX_MIN, 1'b0);
    add_row(mk(MODE_LOAD, 3, 4, 0, 0, 0, 0, 0, FIVE), 1'b1, FIVE, 1'b0);
    add_row(mk(MODE_RIGHT, 3, 4, 0, ONE, 0, ONE, ONE, 0), 1'b1, FIVE, 1'b1);
    add_row(mk(MODE_RIGHT, 3, 4, MU_NEG_ONE, ONE, TWO, ONE, 0, 0), 1'b1, FIVE, 1'b1);
    add_row(mk(MODE_LEFT, 3, 4, MU_ONE, ONE, TWO, ONE, 0, 0), 1'b1, FIVE, 1'b1);
    add_row(mk(MODE_RIGHT, 7, 15, 0, 0, 0, ONE, ONE, 0), 1'b1, FX_MIN, 1'b1);
    add_row(mk(MODE_RIGHT, 3, 4, 34'd1, 0, ONE, ONE, 0, 0));
    add_row(mk(MODE_LEFT, 3, 5, 34'd1, 0, 0, ONE, ONE, 0));
    add_row(mk(MODE_RIGHT, 1, 2, MU_MAX, 1, {1'b0, XS_MAX}, FX_MAX, FX_MAX, 0));
    add_row(mk(MODE_LEFT, 1, 2, MU_MIN, {1'b0, XS_MAX}, 1, FX_MIN, FX_MIN, 0));
    add_row(mk(MODE_RIGHT, 0, 1, MU_ONE, ONE, ONE, FX_MIN, ONE, 0));
    add_row(mk(MODE_LOAD, 0, 2, 0, 0, 0, 0, 0, SEVEN), 1'b1, SEVEN, 1'b0);
    add_row(mk(MODE_REFLECT, 0, 2, 0, 0, 0, 0, 0, 0), 1'b1, SEVEN, 1'b0);
    add_row(mk(MODE_REFLECT, 0, 1, 0, 0, 0, 0, 0, 0), 1'b1, FX_MAX, 1'b0);
    add_row(mk(MODE_LOAD, 5, 9, 0, 0, 0, 0, 0, ONE), 1'b1, ONE, 1'b0);
    add_row(mk(MODE_RIGHT, 5, 9, MU_HALF, ONE, ONE, HALF, QUARTER, 0));
    add_row(mk(MODE_LEFT, 5, 9, MU_HALF, QUARTER, THREE, ONE, NEG_HALF, 0));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_num_dirs(5'd2);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].res);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      in_valid_i <= 1'b0;
      drain_results();
      write_num_dirs(dirs_plan[p]);
      send_idle_pct  = (p % 4 == 1) ? 61 : ((p % 4 == 3) ? 34 : 0);
      recv_stall_pct = (p % 4 == 2) ? 61 : ((p % 4 == 3) ? 34 : 0);
      if (p == 4) begin
        hold_requests++;
      end
      repeat (ITEMS_PER_PHASE) send_item(random_item(), 1'b0, no_result);
    end

    in_valid_i <= 1'b0;
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> diamond_difference_sweep_cell_top.f
+incdir+sv
sv/ddsc_pkg.sv
sv/ddsc_div.sv
sv/ddsc_mul.sv
sv/ddsc_flux_mem.sv
sv/diamond_difference_sweep_cell_top.sv
sv/ddsc_checker.sv
tb/diamond_difference_sweep_cell_top_tb.sv
